// File: sv/rpld_pkg.sv
// Package for the rational polynomial lens distortion core.
// Holds payload structs, state enum and fixed-point constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rpld_pkg;

  localparam int CoefW = 40;
  localparam int CoordW = 24;
  localparam int ValW = 48;           // powers, monomials and terms: +-(2^47-1)
  localparam int AccW = 64;
  localparam logic [ValW-1:0] ValLim = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [AccW-1:0] OneQ10 = 64'd1024;

  localparam logic [0:0] RegDegree = 1'b0;
  localparam logic [0:0] RegShift = 1'b1;

  localparam logic ModeEval = 1'b0;
  localparam logic ModeWrite = 1'b1;

  typedef struct packed {
    logic               mode;
    logic               bank;
    logic [5:0]         coef_pos;
    logic signed [39:0] coeff_value;
    logic signed [23:0] x_coord;
    logic signed [23:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic               zero_denominator;
    logic               overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW_X,
    ST_POW_Y,
    ST_MONO,
    ST_FETCH,
    ST_TERM,
    ST_ACC,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_OUT
  } state_t;

  // Request to the shared multiply unit.
  typedef struct packed {
    logic                   start;
    logic signed [AccW-1:0] a;
    logic signed [AccW-1:0] b;
    logic                   wide_shift;   // 1: shift by 24, 0: shift by 10
  } mul_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [ValW-1:0] p;
    logic                   sat;
  } mul_rsp_t;

endpackage
`default_nettype wire

// File: sv/rpld_ram.sv
// Generic single-port write, single-port registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rpld_ram #(
  parameter int Width = 40,
  parameter int Depth = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/rpld_mul.sv
// Shared multiply-round-saturate unit: round(a*b/2^sh), half away from zero,
// saturated to 48 bits. Uses rpld_pkg. One 24x24 partial product per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rpld_mul
  import rpld_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);
  // Operands magnitudes fit in 48 bits; split each into 24-bit halves so each
  // partial product is 24x24, one per cycle, accumulated into a 96-bit sum.
  logic [47:0] ma, mb;
  logic        neg, wsh;
  logic [1:0]  step;
  logic        busy, fin;
  logic [95:0] prod;
  logic [23:0] pa, pb;
  logic [47:0] pp;
  logic [95:0] rnd;
  logic [95:0] shv;

  always_comb begin
    pa = step[1] ? ma[47:24] : ma[23:0];
    pb = step[0] ? mb[47:24] : mb[23:0];
    pp = pa * pb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
        prod <= '0;
        neg <= req.a[AccW-1] ^ req.b[AccW-1];
        ma <= req.a[AccW-1] ? 48'(-req.a) : req.a[47:0];
        mb <= req.b[AccW-1] ? 48'(-req.b) : req.b[47:0];
        wsh <= req.wide_shift;
      end else if (busy) begin
        prod <= prod + ({48'd0, pp} << (24 * (32'(step[1]) + 32'(step[0]))));
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rnd = prod + (wsh ? 96'h800000 : 96'h200);
    shv = wsh ? (rnd >> 24) : (rnd >> 10);
    rsp.done = fin;
    rsp.sat = (shv > {48'd0, ValLim});
    rsp.p = rsp.sat ? (neg ? -ValLim : ValLim) : (neg ? -shv[47:0] : shv[47:0]);
  end
endmodule
`default_nettype wire

// File: sv/rpld_div.sv
// Restoring radix-2 divider: round(n*2^10/d), half away from zero, saturated
// to 24-bit signed. Uses rpld_pkg. One quotient bit per cycle over 76 bits.
`timescale 1ns / 1ps
`default_nettype none
module rpld_div
  import rpld_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [AccW-1:0] num,
  input  wire logic signed [AccW-1:0] den,
  output logic                        done,
  output logic signed [CoordW-1:0]    quo,
  output logic                        zero,
  output logic                        sat
);
  localparam int NW = 76;
  logic [NW-1:0] dividend, q;
  logic [AccW:0]  rem, trial;
  logic [AccW-1:0] ud;
  logic [6:0] cnt;
  logic busy, neg, dz;
  logic [AccW-1:0] un;

  assign un = num[AccW-1] ? -num : num;
  assign trial = {rem[AccW-1:0], dividend[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dz <= (den == '0);
        neg <= num[AccW-1] ^ den[AccW-1];
        ud <= den[AccW-1] ? -den : den;
        // (un<<10) + ud/2 as the dividend
        dividend <= {2'b00, un, 10'd0} + {12'd0,
                    (den[AccW-1] ? (-den) >> 1 : den >> 1)};
        rem <= '0;
        q <= '0;
        cnt <= 7'(NW);
        busy <= (den != '0);
        done <= (den == '0);
      end else if (busy) begin
        dividend <= dividend << 1;
        if (trial >= {1'b0, ud}) begin
          rem <= trial - {1'b0, ud};
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    zero = dz;
    sat = 1'b0;
    quo = '0;
    if (!dz) begin
      if (neg) begin
        if (q > NW'(8388608)) begin
          sat = 1'b1;
          quo = 24'sh800000;
        end else begin
          quo = 24'(-q);
        end
      end else if (q > NW'(8388607)) begin
        sat = 1'b1;
        quo = 24'sh7FFFFF;
      end else begin
        quo = q[23:0];
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/rational_polynomial_lens_distortion_core.sv
// Top level of the rational polynomial lens distortion core.
// Uses rpld_pkg, rpld_ram, rpld_mul and rpld_div.
//
// Usage: input items arrive on in_valid/in_ready with an in_item_t payload.
// A write item (mode 1) stores one coefficient and makes no result. An
// evaluate item (mode 0) makes one result on out_valid/out_ready.
// Configuration registers (degree, shift) are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, as the block itself does not enforce this. Every multiply runs in
// the shared multiply unit, and each output division in the radix-2 divider.
// Degree d needs 2d power multiplies, and each coefficient takes a monomial
// multiply, a fetch step, a term multiply and an accumulate step, with
// C = 2(d+1)(d+2)-2 coefficients per evaluation.
// Only one item is in work at a time; in_ready is low during evaluation.
// If the receiver stalls, the result waits in the output register and the
// block accepts no new item until it is transferred.
// Reset clears control state; coefficient memory is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module rational_polynomial_lens_distortion_core
  import rpld_pkg::*;
#(
  parameter int MAX_DEGREE = 4,
  parameter int BANK_DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [3:0] cfg_data
);
  localparam int BankAw = $clog2(BANK_DEPTH);
  localparam int DegW = $clog2(MAX_DEGREE + 1);
  localparam int IdxW = 8;

  logic [2:0] poly_degree;
  logic [3:0] norm_shift;
  state_t state, state_next;

  logic signed [ValW-1:0] px [MAX_DEGREE+1];
  logic signed [ValW-1:0] py [MAX_DEGREE+1];
  logic signed [AccW-1:0] acc [4];
  logic signed [ValW-1:0] mono;
  logic signed [AccW-1:0] u, v;
  logic [DegW-1:0] dmax, pdeg, deg, ti;
  logic [1:0] pass;
  logic [IdxW-1:0] idx;
  logic bank, sat, zero, half;
  logic mul_issued;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic div_start, div_done, div_zero, div_sat;
  logic signed [CoordW-1:0] div_q;
  logic [CoefW-1:0] rdata;
  logic [BankAw:0] raddr, waddr;
  logic we, accept;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && !out_valid;

  assign we = accept && (in_data.mode == ModeWrite) &&
              ({2'b00, in_data.coef_pos} < 8'(BANK_DEPTH));
  assign waddr = {in_data.bank, BankAw'(in_data.coef_pos)};
  assign raddr = {bank, idx[BankAw-1:0]};

  rpld_ram #(.Width(CoefW), .Depth(2 ** (BankAw + 1))) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_data.coeff_value),
    .raddr(raddr), .rdata(rdata)
  );

  rpld_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  rpld_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(half ? acc[2] : acc[0]), .den(half ? acc[3] : acc[1]),
    .done(div_done), .quo(div_q), .zero(div_zero), .sat(div_sat)
  );

  // Multiply requests are issued on the first cycle of each compute state.
  always_comb begin
    mreq = '0;
    mreq.start = !mul_issued && (state == ST_POW_X || state == ST_POW_Y ||
                                 state == ST_MONO || state == ST_TERM);
    div_start = (state == ST_DIV_START);
    unique case (state)
      ST_POW_X: begin
        mreq.a = AccW'(px[pdeg - DegW'(1)]);
        mreq.b = u;
      end
      ST_POW_Y: begin
        mreq.a = AccW'(py[pdeg - DegW'(1)]);
        mreq.b = v;
      end
      ST_MONO: begin
        mreq.a = AccW'(px[deg - ti]);
        mreq.b = AccW'(py[ti]);
      end
      ST_TERM: begin
        mreq.a = (idx < IdxW'(BANK_DEPTH)) ? AccW'(signed'(rdata)) : '0;
        mreq.b = AccW'(mono);
        mreq.wide_shift = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:
        if (accept && in_data.mode == ModeEval) state_next = ST_POW_X;
      ST_POW_X: if (mrsp.done) state_next = ST_POW_Y;
      ST_POW_Y:
        if (mrsp.done) state_next = (pdeg == dmax) ? ST_MONO : ST_POW_X;
      ST_MONO: if (mrsp.done) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_TERM;
      ST_TERM: if (mrsp.done) state_next = ST_ACC;
      ST_ACC:
        if (ti == deg && deg == dmax && pass == 2'd3) state_next = ST_DIV_START;
        else state_next = ST_MONO;
      ST_DIV_START: state_next = ST_DIV_RUN;
      ST_DIV_RUN: if (div_done) state_next = ST_DIV_DONE;
      ST_DIV_DONE: state_next = half ? ST_OUT : ST_DIV_START;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      poly_degree <= 3'd1;
      norm_shift <= 4'd0;
      out_valid <= 1'b0;
      mul_issued <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == RegDegree) poly_degree <= cfg_data[2:0];
        else norm_shift <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ST_OUT) out_valid <= 1'b1;
      if (mreq.start) mul_issued <= 1'b1;
      if (mrsp.done) mul_issued <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        bank <= in_data.bank;
        u <= AccW'(in_data.x_coord >>> norm_shift);
        v <= AccW'(in_data.y_coord >>> norm_shift);
        if (poly_degree == 3'd0) dmax <= DegW'(1);
        else if (32'(poly_degree) > MAX_DEGREE) dmax <= DegW'(MAX_DEGREE);
        else dmax <= DegW'(poly_degree);
        px[0] <= ValW'(1024);
        py[0] <= ValW'(1024);
        pdeg <= DegW'(1);
        sat <= 1'b0;
        zero <= 1'b0;
        half <= 1'b0;
        acc[0] <= '0; acc[1] <= OneQ10; acc[2] <= '0; acc[3] <= OneQ10;
        pass <= 2'd0;
        deg <= '0;
        ti <= '0;
        idx <= '0;
      end
      ST_POW_X: if (mrsp.done) begin
        px[pdeg] <= mrsp.p;
        sat <= sat | mrsp.sat;
      end
      ST_POW_Y: if (mrsp.done) begin
        py[pdeg] <= mrsp.p;
        sat <= sat | mrsp.sat;
        pdeg <= pdeg + DegW'(1);
      end
      ST_MONO: if (mrsp.done) begin
        mono <= mrsp.p;
        sat <= sat | mrsp.sat;
      end
      ST_TERM: if (mrsp.done) begin
        acc[pass] <= acc[pass] + AccW'(mrsp.p);
        sat <= sat | mrsp.sat;
      end
      ST_ACC: begin
        idx <= idx + IdxW'(1);
        if (ti != deg) ti <= ti + DegW'(1);
        else begin
          ti <= '0;
          if (deg != dmax) deg <= deg + DegW'(1);
          else begin
            pass <= pass + 2'd1;
            deg <= pass[0] ? DegW'(0) : DegW'(1);
          end
        end
      end
      ST_DIV_DONE: begin
        zero <= zero | div_zero;
        sat <= sat | div_sat;
        if (half) out_data.out_y <= div_q;
        else out_data.out_x <= div_q;
        half <= 1'b1;
      end
      ST_OUT: begin
        out_data.zero_denominator <= zero;
        out_data.overflow <= sat;
      end
      default: ;
    endcase
  end

  ap_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE) else $error("ready outside idle");
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  ap_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
endmodule
`default_nettype wire

// File: dv/rational_polynomial_lens_distortion_core_tb.sv
// Self-checking testbench for the rational polynomial lens distortion core.
// Depends on rpld_pkg and the core RTL; predicts every result with its own
// fixed-point evaluator and compares the results field by field.
`timescale 1ns / 1ps
module rational_polynomial_lens_distortion_core_tb;
  import rpld_pkg::*;

  localparam int NumCoef = 64;
  localparam int CycleLimit = 3000000;
  localparam logic [63:0] TermMax = 64'h0000_7FFF_FFFF_FFFF;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_index = RegDegree;
  logic [3:0] cfg_data = '0;

  rational_polynomial_lens_distortion_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow state of the block.
  logic signed [39:0] coef_shadow [2][NumCoef];
  logic [2:0] degree_reg = 3'd1;
  logic [3:0] shift_reg = 4'd0;

  in_item_t  pending_items[$];
  out_item_t expected_points[$];
  int unsigned mismatches = 0;
  int unsigned points_checked = 0;
  int unsigned zero_den_seen = 0;
  int unsigned overflow_seen = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit steady = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // round(a * b / 2^sh), half away from zero, saturated to +-(2^47 - 1).
  function automatic longint scale_mul(longint a, longint b, int sh, inout bit sat);
    logic [63:0] ma, mb;
    logic [127:0] prod;
    logic [63:0] mag;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    prod = ({64'd0, ma} * {64'd0, mb} + (128'd1 << (sh - 1))) >> sh;
    if (prod > {64'd0, TermMax}) begin
      sat = 1'b1;
      mag = TermMax;
    end else begin
      mag = prod[63:0];
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [23:0] ratio_q10(longint n, longint d, inout bit zero,
                                            inout bit sat);
    logic [63:0] un, ud, q;
    bit neg;
    if (d == 0) begin
      zero = 1'b1;
      return '0;
    end
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = ((un << 10) + (ud >> 1)) / ud;
    if (neg) begin
      if (q > 64'd8388608) begin
        q = 64'd8388608;
        sat = 1'b1;
      end
      return 24'(-q);
    end
    if (q > 64'd8388607) begin
      q = 64'd8388607;
      sat = 1'b1;
    end
    return q[23:0];
  endfunction

  // Applies one accepted item to the shadow state; evaluations queue a result.
  function automatic void apply_item(in_item_t it);
    int deg_top, idx, k, i, pass;
    longint px[5], py[5], acc[4];
    longint u, v, mono, c;
    bit sat, zero;
    out_item_t res;
    if (it.mode == ModeWrite) begin
      coef_shadow[it.bank][it.coef_pos] = it.coeff_value;
      return;
    end
    deg_top = degree_reg;
    if (deg_top < 1) deg_top = 1;
    if (deg_top > 4) deg_top = 4;
    sat = 1'b0;
    zero = 1'b0;
    u = longint'(it.x_coord) >>> shift_reg;
    v = longint'(it.y_coord) >>> shift_reg;
    px[0] = 1024;
    py[0] = 1024;
    for (k = 1; k <= deg_top; k++) begin
      px[k] = scale_mul(px[k-1], u, 10, sat);
      py[k] = scale_mul(py[k-1], v, 10, sat);
    end
    acc[0] = 0; acc[1] = 1024; acc[2] = 0; acc[3] = 1024;
    idx = 0;
    for (pass = 0; pass < 4; pass++) begin
      for (k = pass % 2; k <= deg_top; k++) begin
        for (i = 0; i <= k; i++) begin
          mono = scale_mul(px[k-i], py[i], 10, sat);
          c = longint'(coef_shadow[it.bank][idx]);
          acc[pass] += scale_mul(c, mono, 24, sat);
          idx++;
        end
      end
    end
    res.out_x = ratio_q10(acc[0], acc[1], zero, sat);
    res.out_y = ratio_q10(acc[2], acc[3], zero, sat);
    res.zero_denominator = zero;
    res.overflow = sat;
    expected_points = {expected_points, res};
  endfunction

  // Sender: presents queued items, holding each until its transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) apply_item(in_data);
      if (in_valid && !in_ready) begin
        // hold
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls and result checking.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          out_item_t want;
          want = expected_points.pop_front();
          points_checked++;
          if (want.zero_denominator) zero_den_seen++;
          if (want.overflow) overflow_seen++;
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%0d y=%0d zd=%b ov=%b, got x=%0d y=%0d zd=%b ov=%b",
                       want.out_x, want.out_y, want.zero_denominator, want.overflow,
                       out_data.out_x, out_data.out_y, out_data.zero_denominator,
                       out_data.overflow);
          end
        end
      end
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("rational_polynomial_lens_distortion_core_tb: errors");
      $finish;
    end
  end

  task automatic push_write(logic bank, logic [5:0] idx, logic signed [39:0] val);
    in_item_t it;
    it = '0;
    it.mode = ModeWrite;
    it.bank = bank;
    it.coef_pos = idx;
    it.coeff_value = val;
    it.x_coord = 24'($urandom);
    it.y_coord = 24'($urandom);
    pending_items = {pending_items, it};
  endtask

  task automatic push_point(logic bank, logic signed [23:0] x, logic signed [23:0] y);
    in_item_t it;
    it = '0;
    it.mode = ModeEval;
    it.bank = bank;
    it.coef_pos = 6'($urandom);
    it.coeff_value = {8'($urandom), 32'($urandom)};
    it.x_coord = x;
    it.y_coord = y;
    pending_items = {pending_items, it};
  endtask

  function automatic logic signed [39:0] rand_coef();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 40'(signed'($urandom_range(0, 1 << 23)) - (1 << 22));
    if (r < 80) return 40'(signed'($urandom_range(0, 1 << 27)) - (1 << 26));
    if (r < 90) return 40'(signed'($urandom_range(0, 510)) - 255);
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic signed [23:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 24'($urandom);
    if (r < 80) return 24'(signed'($urandom_range(0, 1 << 15)) - (1 << 14));
    if (r < 90) return 24'sh7FFFFF;
    return 24'sh800000;
  endfunction

  // Waits until the sender is empty and every expected result has arrived.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegDegree) degree_reg = val[2:0];
    else shift_reg = val;
  endtask

  int unsigned degree_plan[10] = '{1, 2, 3, 4, 0, 5, 7, 4, 1, 2};
  int unsigned shift_plan[10] = '{0, 3, 12, 15, 13, 6, 0, 9, 14, 1};

  initial begin
    int b, j, ph, n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Every coefficient is written before any evaluation reads it.
    for (b = 0; b < 2; b++)
      for (j = 0; j < NumCoef; j++)
        push_write(b[0], j[5:0], 40'(signed'($urandom_range(0, 1 << 21)) - (1 << 20)));
    // Identity terms for degree one: x numerator x term, y numerator y term.
    push_write(1'b0, 6'd1, 40'sd16777216);
    push_write(1'b0, 6'd7, 40'sd16777216);

    // Directed points at the reset configuration.
    push_point(1'b0, 24'sd0, 24'sd0);
    push_point(1'b0, 24'sd1024, -24'sd1024);
    push_point(1'b0, 24'sh7FFFFF, 24'sh7FFFFF);
    push_point(1'b0, 24'sh800000, 24'sh800000);
    push_point(1'b0, 24'sh7FFFFF, 24'sh800000);
    push_point(1'b1, 24'sh800000, 24'sh7FFFFF);
    push_point(1'b1, -24'sd1, 24'sd1);
    // A zero x denominator: the x term of the denominator cancels the constant.
    push_write(1'b1, 6'd3, -40'sd16777216);
    push_write(1'b1, 6'd4, 40'sd0);
    push_point(1'b1, 24'sd1024, 24'sd0);
    // Extreme coefficients force saturation.
    push_write(1'b0, 6'd1, 40'sh7F_FFFF_FFFF);
    push_point(1'b0, 24'sh7FFFFF, 24'sd100);
    push_write(1'b0, 6'd1, 40'sh80_0000_0000);
    push_point(1'b0, 24'sh7FFFFF, -24'sd100);
    push_write(1'b0, 6'd1, 40'sd16777216);
    push_point(1'b0, 24'sd5000, 24'sd3000);
    drain();

    // Random phases over several register settings; each drain is a full pause.
    for (ph = 0; ph < 10; ph++) begin
      steady = (ph % 4 == 2);
      set_reg(RegDegree, 4'(degree_plan[ph] + ((ph == 6) ? 8 : 0)));
      set_reg(RegShift, 4'(shift_plan[ph]));
      for (n = 0; n < 8; n++)
        push_write(1'($urandom), 6'($urandom_range(0, 63)), rand_coef());
      for (n = 0; n < 18; n++) begin
        if ($urandom_range(0, 99) < 80) push_point(1'($urandom), rand_coord(), rand_coord());
        else push_write(1'($urandom), 6'($urandom_range(0, 63)), rand_coef());
      end
      drain();
    end

    $display("Checked %0d points over degrees 0..7 and shifts 0..15 in both banks;",
             points_checked);
    $display("%0d had a zero denominator and %0d saturated.", zero_den_seen, overflow_seen);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("rational_polynomial_lens_distortion_core_tb: clean");
    end else begin
      $display("rational_polynomial_lens_distortion_core_tb: errors");
    end
    $finish;
  end

endmodule
